// ----- rtl/rcm_pkg.sv -----
package rcm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CNT_W     = 32;
	localparam int DATA_W    = 32;
	localparam int ACC_W     = 64;
	localparam int MOM_W     = 48;
	localparam int MPLR_W    = 34;
	localparam int PROD_W    = ACC_W + MPLR_W;
	localparam int DVSR_W    = CNT_W + 1;
	localparam int DIFF_W    = 100;
	localparam int STEP_W    = 6;

	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(ACC_W - 1);
	localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MPLR_W - 1);

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DIV_DN,
		OP_MUL_T,
		OP_MUL_A1,
		OP_MUL_A2,
		OP_MUL_B,
		OP_DIV_M2,
		OP_DIV_M3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_DN_GO,
		ST_DN_WAIT,
		ST_T_GO,
		ST_T_WAIT,
		ST_A1_GO,
		ST_A1_WAIT,
		ST_A2_GO,
		ST_A2_WAIT,
		ST_B_GO,
		ST_B_WAIT,
		ST_UPD,
		ST_Q2_GO,
		ST_Q2_WAIT,
		ST_Q3_GO,
		ST_Q3_WAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic start;
		logic capture;
		logic upd;
		logic fin;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic count_max;
		logic unit_done;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        count;
		logic signed [31:0] mean;
		logic [47:0]        second_moment;
		logic signed [47:0] third_moment;
		logic               overflow;
	} out_item_t;

endpackage

// ----- rtl/rcm_stream_if.sv -----
interface rcm_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/rcm_dp.sv -----
module rcm_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rcm_pkg::cmd_t     cmd,
	input  rcm_pkg::in_item_t in_item,
	input  logic              out_ready,
	output logic              out_valid,
	output rcm_pkg::out_item_t out_item,
	output rcm_pkg::sts_t     sts
);

	localparam int F      = rcm_pkg::FRAC_BITS;
	localparam int ACC_W  = rcm_pkg::ACC_W;
	localparam int MPLR_W = rcm_pkg::MPLR_W;
	localparam int PROD_W = rcm_pkg::PROD_W;
	localparam int DVSR_W = rcm_pkg::DVSR_W;
	localparam int DIFF_W = rcm_pkg::DIFF_W;
	localparam int MOM_W  = rcm_pkg::MOM_W;
	localparam int STEP_W = rcm_pkg::STEP_W;

	// statistics state
	logic [31:0]        count_q;
	logic [31:0]        mean_q;
	logic [ACC_W-1:0]   m2_q;
	logic [ACC_W-1:0]   m3_q;
	logic               sat_q;

	// per-request working registers
	logic [31:0]        x_q;
	logic [DVSR_W-1:0]  n_q;
	logic [32:0]        d_q;
	logic [32:0]        adn_q;
	logic               dn_neg_q;
	logic [32:0]        e_q;
	logic [ACC_W-1:0]   t_q;
	logic [ACC_W-1:0]   a_q;
	logic [95:0]        big_a_q;
	logic [PROD_W-F-1:0] big_b_q;
	logic [MOM_W-1:0]   sec_q;
	logic [MOM_W-1:0]   thr_q;

	// shared iterative unit
	logic                      busy_q;
	logic                      done_q;
	logic                      is_div_q;
	logic [rcm_pkg::STEP_W-1:0] step_q;
	logic [ACC_W-1:0]          quo_q;
	logic [DVSR_W:0]           rem_q;
	logic [DVSR_W-1:0]         dvsr_q;
	logic [PROD_W-1:0]         acc_q;
	logic [ACC_W-1:0]          mcand_q;

	logic                out_valid_q;
	rcm_pkg::out_item_t  out_q;

	logic [32:0]        ad;
	logic [32:0]        dn_w;
	logic [31:0]        m_w;
	logic [34:0]        adn3;
	logic [ACC_W-1:0]   am3;
	logic [ACC_W-1:0]   op_dvd;
	logic [DVSR_W-1:0]  op_dvsr;
	logic [ACC_W-1:0]   op_mcand;
	logic [MPLR_W-1:0]  op_mplr;
	logic               op_is_div;
	logic [DVSR_W:0]    rem_try;
	logic               rem_ge;
	logic [ACC_W:0]     mul_sum;
	logic [DIFF_W-1:0]  diff_w;
	logic [DIFF_W-1:0]  sd_w;
	logic [DIFF_W-1:0]  m3_sum;
	logic               m3_ovf;
	logic [ACC_W:0]     m2_sum;
	logic [ACC_W-1:0]   q3_mag;

	assign ad     = d_q[32] ? (~d_q + 33'd1) : d_q;
	assign dn_w   = dn_neg_q ? (~adn_q + 33'd1) : adn_q;
	assign m_w    = (n_q == DVSR_W'(1)) ? 32'd0 : 32'(n_q - DVSR_W'(2));
	assign adn3   = {1'b0, adn_q, 1'b0} + {2'b00, adn_q};
	assign am3    = m3_q[ACC_W-1] ? (~m3_q + ACC_W'(1)) : m3_q;
	assign q3_mag = quo_q;

	always_comb begin
		op_dvd    = '0;
		op_dvsr   = {1'b0, count_q};
		op_mcand  = '0;
		op_mplr   = '0;
		op_is_div = 1'b0;
		unique case (cmd.op)
			rcm_pkg::OP_DIV_DN: begin
				op_dvd    = ACC_W'(ad);
				op_dvsr   = n_q;
				op_is_div = 1'b1;
			end
			rcm_pkg::OP_DIV_M2: begin
				op_dvd    = m2_q;
				op_is_div = 1'b1;
			end
			rcm_pkg::OP_DIV_M3: begin
				op_dvd    = am3;
				op_is_div = 1'b1;
			end
			rcm_pkg::OP_MUL_T: begin
				op_mcand = ACC_W'(ad);
				op_mplr  = MPLR_W'(e_q);
			end
			rcm_pkg::OP_MUL_A1: begin
				op_mcand = t_q;
				op_mplr  = MPLR_W'(adn_q);
			end
			rcm_pkg::OP_MUL_A2: begin
				op_mcand = a_q;
				op_mplr  = MPLR_W'(m_w);
			end
			rcm_pkg::OP_MUL_B: begin
				op_mcand = m2_q;
				op_mplr  = adn3[MPLR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign rem_try = {rem_q[DVSR_W-1:0], quo_q[ACC_W-1]};
	assign rem_ge  = rem_try >= {1'b0, dvsr_q};
	assign mul_sum = {1'b0, acc_q[PROD_W-1:MPLR_W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

	// restoring divide one bit a cycle, shift-add multiply one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == (is_div_q ? rcm_pkg::DIV_LAST : rcm_pkg::MUL_LAST)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			is_div_q <= op_is_div;
			step_q   <= '0;
			quo_q    <= op_dvd;
			rem_q    <= '0;
			dvsr_q   <= op_dvsr;
			acc_q    <= {{ACC_W{1'b0}}, op_mplr};
			mcand_q  <= op_mcand;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (is_div_q) begin
				rem_q <= rem_ge ? (rem_try - {1'b0, dvsr_q}) : rem_try;
				quo_q <= {quo_q[ACC_W-2:0], rem_ge};
			end else begin
				acc_q <= {mul_sum, acc_q[MPLR_W-1:1]};
			end
		end
	end

	assign diff_w = {4'b0, big_a_q} - {{(DIFF_W-PROD_W+F){1'b0}}, big_b_q};
	// subtract the other way round for a negative step instead of negating
	assign sd_w   = dn_neg_q ? ({{(DIFF_W-PROD_W+F){1'b0}}, big_b_q} - {4'b0, big_a_q})
		: diff_w;
	assign m3_sum = sd_w + {{(DIFF_W-ACC_W){m3_q[ACC_W-1]}}, m3_q};
	assign m3_ovf = !((&m3_sum[DIFF_W-1:ACC_W-1]) || !(|m3_sum[DIFF_W-1:ACC_W-1]));
	assign m2_sum = {1'b0, m2_q} + {1'b0, t_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
			m3_q    <= '0;
			sat_q   <= 1'b0;
		end else if (cmd.accept) begin
			if (in_item.kind) begin
				count_q <= '0;
				mean_q  <= '0;
				m2_q    <= '0;
				m3_q    <= '0;
				sat_q   <= 1'b0;
			end else if (&count_q) begin
				sat_q <= 1'b1;
			end
		end else if (cmd.upd) begin
			count_q <= n_q[31:0];
			mean_q  <= mean_q + dn_w[31:0];
			m2_q    <= m2_sum[ACC_W] ? '1 : m2_sum[ACC_W-1:0];
			if (m3_ovf) begin
				m3_q <= m3_sum[DIFF_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
			end else begin
				m3_q <= m3_sum[ACC_W-1:0];
			end
			if (m2_sum[ACC_W] || m3_ovf) begin
				sat_q <= 1'b1;
			end
		end else if (cmd.capture && cmd.op == rcm_pkg::OP_DIV_M2) begin
			if (|quo_q[ACC_W-1:MOM_W]) begin
				sat_q <= 1'b1;
			end
		end else if (cmd.capture && cmd.op == rcm_pkg::OP_DIV_M3) begin
			if (m3_q[ACC_W-1] ? (q3_mag > {{(ACC_W-MOM_W){1'b0}}, 1'b1, {(MOM_W-1){1'b0}}})
				: (|q3_mag[ACC_W-1:MOM_W-1])) begin
				sat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q <= in_item.sample;
		end
		if (cmd.prep) begin
			n_q <= {1'b0, count_q} + DVSR_W'(1);
			d_q <= {x_q[31], x_q} - {mean_q[31], mean_q};
		end
		if (cmd.capture) begin
			unique case (cmd.op)
				rcm_pkg::OP_DIV_DN: begin
					adn_q    <= quo_q[32:0];
					dn_neg_q <= d_q[32] && (|quo_q[32:0]);
					e_q      <= ad - quo_q[32:0];
				end
				rcm_pkg::OP_MUL_T:  t_q     <= acc_q[F +: ACC_W];
				rcm_pkg::OP_MUL_A1: a_q     <= acc_q[F +: ACC_W];
				rcm_pkg::OP_MUL_A2: big_a_q <= acc_q[95:0];
				rcm_pkg::OP_MUL_B:  big_b_q <= acc_q[PROD_W-1:F];
				rcm_pkg::OP_DIV_M2: begin
					sec_q <= (|quo_q[ACC_W-1:MOM_W]) ? '1 : quo_q[MOM_W-1:0];
				end
				rcm_pkg::OP_DIV_M3: begin
					if (m3_q[ACC_W-1]) begin
						if (q3_mag > {{(ACC_W-MOM_W){1'b0}}, 1'b1, {(MOM_W-1){1'b0}}}) begin
							thr_q <= {1'b1, {(MOM_W-1){1'b0}}};
						end else begin
							thr_q <= ~q3_mag[MOM_W-1:0] + MOM_W'(1);
						end
					end else if (|q3_mag[ACC_W-1:MOM_W-1]) begin
						thr_q <= {1'b0, {(MOM_W-1){1'b1}}};
					end else begin
						thr_q <= q3_mag[MOM_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register: holds a finished result while the next request runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.count         <= count_q;
			out_q.mean          <= mean_q;
			out_q.second_moment <= (count_q == '0) ? '0 : sec_q;
			out_q.third_moment  <= (count_q == '0) ? '0 : thr_q;
			out_q.overflow      <= sat_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_item      = out_q;
	assign sts.count_max = &count_q;
	assign sts.unit_done = done_q;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// ----- rtl/rcm_ctrl.sv -----
module rcm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_kind,
	input  rcm_pkg::sts_t sts,
	output logic          in_ready,
	output rcm_pkg::cmd_t cmd
);

	rcm_pkg::state_t state_q;
	rcm_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rcm_pkg::ST_IDLE: begin
				if (in_valid) begin
					priority if (in_kind) state_nxt = rcm_pkg::ST_FIN;
					else if (sts.count_max) state_nxt = rcm_pkg::ST_Q2_GO;
					else state_nxt = rcm_pkg::ST_PREP;
				end
			end
			rcm_pkg::ST_PREP:    state_nxt = rcm_pkg::ST_DN_GO;
			rcm_pkg::ST_DN_GO:   state_nxt = rcm_pkg::ST_DN_WAIT;
			rcm_pkg::ST_DN_WAIT: if (sts.unit_done) state_nxt = rcm_pkg::ST_T_GO;
			rcm_pkg::ST_T_GO:    state_nxt = rcm_pkg::ST_T_WAIT;
			rcm_pkg::ST_T_WAIT:  if (sts.unit_done) state_nxt = rcm_pkg::ST_A1_GO;
			rcm_pkg::ST_A1_GO:   state_nxt = rcm_pkg::ST_A1_WAIT;
			rcm_pkg::ST_A1_WAIT: if (sts.unit_done) state_nxt = rcm_pkg::ST_A2_GO;
			rcm_pkg::ST_A2_GO:   state_nxt = rcm_pkg::ST_A2_WAIT;
			rcm_pkg::ST_A2_WAIT: if (sts.unit_done) state_nxt = rcm_pkg::ST_B_GO;
			rcm_pkg::ST_B_GO:    state_nxt = rcm_pkg::ST_B_WAIT;
			rcm_pkg::ST_B_WAIT:  if (sts.unit_done) state_nxt = rcm_pkg::ST_UPD;
			rcm_pkg::ST_UPD:     state_nxt = rcm_pkg::ST_Q2_GO;
			rcm_pkg::ST_Q2_GO:   state_nxt = rcm_pkg::ST_Q2_WAIT;
			rcm_pkg::ST_Q2_WAIT: if (sts.unit_done) state_nxt = rcm_pkg::ST_Q3_GO;
			rcm_pkg::ST_Q3_GO:   state_nxt = rcm_pkg::ST_Q3_WAIT;
			rcm_pkg::ST_Q3_WAIT: if (sts.unit_done) state_nxt = rcm_pkg::ST_FIN;
			rcm_pkg::ST_FIN:     if (sts.out_free) state_nxt = rcm_pkg::ST_IDLE;
			default:             state_nxt = rcm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = rcm_pkg::OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			rcm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			rcm_pkg::ST_PREP: cmd.prep = 1'b1;
			rcm_pkg::ST_DN_GO: begin
				cmd.op    = rcm_pkg::OP_DIV_DN;
				cmd.start = 1'b1;
			end
			rcm_pkg::ST_DN_WAIT: begin
				cmd.op      = rcm_pkg::OP_DIV_DN;
				cmd.capture = sts.unit_done;
			end
			rcm_pkg::ST_T_GO: begin
				cmd.op    = rcm_pkg::OP_MUL_T;
				cmd.start = 1'b1;
			end
			rcm_pkg::ST_T_WAIT: begin
				cmd.op      = rcm_pkg::OP_MUL_T;
				cmd.capture = sts.unit_done;
			end
			rcm_pkg::ST_A1_GO: begin
				cmd.op    = rcm_pkg::OP_MUL_A1;
				cmd.start = 1'b1;
			end
			rcm_pkg::ST_A1_WAIT: begin
				cmd.op      = rcm_pkg::OP_MUL_A1;
				cmd.capture = sts.unit_done;
			end
			rcm_pkg::ST_A2_GO: begin
				cmd.op    = rcm_pkg::OP_MUL_A2;
				cmd.start = 1'b1;
			end
			rcm_pkg::ST_A2_WAIT: begin
				cmd.op      = rcm_pkg::OP_MUL_A2;
				cmd.capture = sts.unit_done;
			end
			rcm_pkg::ST_B_GO: begin
				cmd.op    = rcm_pkg::OP_MUL_B;
				cmd.start = 1'b1;
			end
			rcm_pkg::ST_B_WAIT: begin
				cmd.op      = rcm_pkg::OP_MUL_B;
				cmd.capture = sts.unit_done;
			end
			rcm_pkg::ST_UPD: cmd.upd = 1'b1;
			rcm_pkg::ST_Q2_GO: begin
				cmd.op    = rcm_pkg::OP_DIV_M2;
				cmd.start = 1'b1;
			end
			rcm_pkg::ST_Q2_WAIT: begin
				cmd.op      = rcm_pkg::OP_DIV_M2;
				cmd.capture = sts.unit_done;
			end
			rcm_pkg::ST_Q3_GO: begin
				cmd.op    = rcm_pkg::OP_DIV_M3;
				cmd.start = 1'b1;
			end
			rcm_pkg::ST_Q3_WAIT: begin
				cmd.op      = rcm_pkg::OP_DIV_M3;
				cmd.capture = sts.unit_done;
			end
			rcm_pkg::ST_FIN: cmd.fin = sts.out_free;
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/running_central_moments_core.sv -----
// Running count, mean, second and third central moments of a sample stream.
// sample_in carries requests: kind 0 pushes a signed Q16.16 sample, kind 1
// clears all statistics. Every request gives one result on stats_out: count,
// mean, M2/n, M3/n and a sticky overflow flag that a clear drops.
// A push runs, between acceptance and result, one 64-step restoring
// divider three times (mean step, M2/n, M3/n) and one 34-step shift-add
// multiplier four times. A clear goes straight to the final state, which
// loads its result once the output register is free; a push at full count
// skips the update and runs only the M2/n and M3/n divisions. One request
// is in work at a time; sample_in.ready rises again as the result is loaded.
// The result sits in an output register, so a new request is taken while
// stats_out waits; if the receiver still stalls when the next result is done,
// the block holds that result until the register frees.
// Reset clears all statistics, the flag and the output channel's valid state.
module running_central_moments_core (
	input logic         clk,
	input logic         arst_n,
	rcm_stream_if.sink   sample_in,
	rcm_stream_if.source stats_out
);

	rcm_pkg::cmd_t      cmd;
	rcm_pkg::sts_t      sts;
	rcm_pkg::in_item_t  in_item;
	rcm_pkg::out_item_t out_item;
	logic               in_ready;
	logic               out_valid;

	assign in_item = sample_in.data;

	rcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_in.valid),
		.in_kind  (in_item.kind),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	rcm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.out_ready (stats_out.ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.sts       (sts)
	);

	assign sample_in.ready = in_ready;
	assign stats_out.valid = out_valid;
	assign stats_out.data  = out_item;

endmodule

// ----- sim/running_central_moments_core_tb.sv -----
module running_central_moments_core_tb;

	localparam int          IDLE_PCT    = 16;
	localparam int          DRAIN_WAIT  = 400;
	localparam longint      CYCLE_LIMIT = 2_000_000;
	localparam logic        KIND_PUSH   = 1'b0;
	localparam logic        KIND_CLEAR  = 1'b1;
	localparam logic [63:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;
	localparam logic [63:0] OUT2_MAX    = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0] OUT3_POS    = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] OUT3_NEG    = 64'h0000_8000_0000_0000;
	localparam logic [63:0] CNT_FULL    = 64'h0000_0000_FFFF_FFFF;

	logic clk;
	logic arst_n;

	rcm_stream_if #(.T(rcm_pkg::in_item_t))  sample_in();
	rcm_stream_if #(.T(rcm_pkg::out_item_t)) stats_out();

	running_central_moments_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_in(sample_in.sink),
		.stats_out(stats_out.source)
	);

	// predictor state
	logic [31:0] st_count;
	longint      st_mean;
	logic [63:0] st_m2;
	logic [63:0] st_m3;
	logic        st_sat;

	rcm_pkg::out_item_t expected_stats[$];
	bit          idle_on;
	int          errors;
	int          n_push;
	int          n_clear;
	int          n_ovf_seen;
	longint      cycles;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic void pred_clear();
		st_count = '0;
		st_mean  = 0;
		st_m2    = '0;
		st_m3    = '0;
		st_sat   = 1'b0;
	endfunction

	function automatic void pred_push(input longint x);
		logic [63:0]  n, ad, adn, adn3, t, m;
		longint       d, dn;
		logic [127:0] a, b, diff, acc;
		logic [64:0]  sum2;
		logic         sat;
		sat = 1'b0;
		if (64'(st_count) == CNT_FULL) begin
			st_sat = 1'b1;
			return;
		end
		n    = 64'(st_count) + 64'd1;
		d    = x - st_mean;
		dn   = d / longint'(n);
		ad   = magnitude(d);
		adn  = magnitude(dn);
		t    = 64'((128'(ad) * 128'(magnitude(d - dn))) >> rcm_pkg::FRAC_BITS);
		a    = (128'(t) * 128'(adn)) >> rcm_pkg::FRAC_BITS;
		m    = (n >= 64'd2) ? n - 64'd2 : 64'd0;
		a    = a * 128'(m);
		if (a[127:64] >= 64'h4000_0000_0000_0000)
			a = {64'h4000_0000_0000_0000, 64'd0};
		adn3 = adn * 64'd3;
		b    = (128'(st_m2) * 128'(adn3)) >> rcm_pkg::FRAC_BITS;
		diff = a - b;
		if (dn < 0)
			diff = -diff;
		acc = {{64{st_m3[63]}}, st_m3} + diff;
		if (acc[127:63] == '0 || acc[127:63] == '1) begin
			st_m3 = acc[63:0];
		end else begin
			sat   = 1'b1;
			st_m3 = acc[127] ? S64_MIN : S64_MAX;
		end
		sum2 = {1'b0, st_m2} + {1'b0, t};
		if (sum2[64]) begin
			st_m2 = '1;
			sat   = 1'b1;
		end else begin
			st_m2 = sum2[63:0];
		end
		st_mean  = st_mean + dn;
		st_count = n[31:0];
		if (sat)
			st_sat = 1'b1;
	endfunction

	function automatic rcm_pkg::out_item_t moments_update(input rcm_pkg::in_item_t req);
		rcm_pkg::out_item_t r;
		logic [63:0]        q;
		if (req.kind == KIND_CLEAR)
			pred_clear();
		else
			pred_push(longint'(req.sample));
		r = '0;
		if (st_count != 0) begin
			q = st_m2 / 64'(st_count);
			if (q > OUT2_MAX) begin
				q      = OUT2_MAX;
				st_sat = 1'b1;
			end
			r.second_moment = q[47:0];
			q = magnitude(longint'(st_m3)) / 64'(st_count);
			if (st_m3[63]) begin
				if (q > OUT3_NEG) begin
					q      = OUT3_NEG;
					st_sat = 1'b1;
				end
				r.third_moment = 48'(64'd0 - q);
			end else begin
				if (q > OUT3_POS) begin
					q      = OUT3_POS;
					st_sat = 1'b1;
				end
				r.third_moment = q[47:0];
			end
		end
		r.count    = st_count;
		r.mean     = 32'(st_mean);
		r.overflow = st_sat;
		return r;
	endfunction

	// one request: optional idle gap, then hold valid until accepted
	task automatic send_req(input logic kind, input logic [31:0] sample);
		rcm_pkg::in_item_t req;
		req.kind   = kind;
		req.sample = sample;
		if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		sample_in.valid <= 1'b1;
		sample_in.data  <= req;
		do @(posedge clk); while (!sample_in.ready);
		expected_stats.push_back(moments_update(req));
		if (kind == KIND_CLEAR)
			n_clear++;
		else
			n_push++;
	endtask

	task automatic push_sample(input logic [31:0] s);
		send_req(KIND_PUSH, s);
	endtask

	task automatic clear_stats();
		send_req(KIND_CLEAR, $urandom());
	endtask

	task automatic wait_drained();
		sample_in.valid <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_sample(input int profile);
		case (profile)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
			2: return 32'($signed($urandom_range(0, 65536 * 8)) - 65536 * 4 + 65536 * 50);
			default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
				: 32'h8000_0000 + $urandom_range(0, 255);
		endcase
	endfunction

	task automatic test_directed();
		clear_stats();
		push_sample(32'h0000_0000);
		push_sample(32'h7FFF_FFFF);
		push_sample(32'h8000_0000);
		push_sample(32'h8000_0000);
		push_sample(32'h7FFF_FFFF);
		push_sample(32'hFFFF_FFFF);
		clear_stats();
		push_sample(32'hFFFF_FFFF);
		push_sample(32'h0000_0001);
		push_sample(32'h0001_0000);
		push_sample(32'hFFFF_0000);
		push_sample(32'h0003_8000);
		clear_stats();
		push_sample(32'h8000_0000);
		push_sample(32'h8000_0000);
		push_sample(32'h7FFF_FFFF);
		clear_stats();
		push_sample(32'h5555_5555);
		push_sample(32'hAAAA_AAAA);
		clear_stats();
	endtask

	task automatic test_random(input int items);
		int profile;
		profile = $urandom_range(0, 3);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 99) < 4) begin
				clear_stats();
				profile = $urandom_range(0, 3);
			end else begin
				push_sample(pick_sample($urandom_range(0, 9) == 0 ? 0 : profile));
			end
		end
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 10; i++)
			push_sample(pick_sample(1));
		wait_drained();
		for (int i = 0; i < 10; i++)
			push_sample(pick_sample(2));
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		test_random(150);
		idle_on = 1'b1;
	endtask

	// result checker and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_out.ready <= 1'b0;
		end else begin
			if (stats_out.valid && stats_out.ready) begin
				if (expected_stats.size() == 0) begin
					$display("%0t: unexpected result %p", $time, stats_out.data);
					errors++;
				end else begin
					rcm_pkg::out_item_t e;
					rcm_pkg::out_item_t g;
					e = expected_stats.pop_front();
					g = stats_out.data;
					if (g.overflow)
						n_ovf_seen++;
					if (g.count !== e.count) begin
						$display("%0t: count exp %0d got %0d", $time, e.count, g.count);
						errors++;
					end
					if (g.mean !== e.mean) begin
						$display("%0t: mean exp %0d got %0d", $time, e.mean, g.mean);
						errors++;
					end
					if (g.second_moment !== e.second_moment) begin
						$display("%0t: second_moment exp %h got %h", $time,
							e.second_moment, g.second_moment);
						errors++;
					end
					if (g.third_moment !== e.third_moment) begin
						$display("%0t: third_moment exp %h got %h", $time,
							e.third_moment, g.third_moment);
						errors++;
					end
					if (g.overflow !== e.overflow) begin
						$display("%0t: overflow exp %b got %b", $time, e.overflow, g.overflow);
						errors++;
					end
				end
			end
			stats_out.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		sample_in.valid = 1'b0;
		sample_in.data  = '0;
		idle_on         = 1'b1;
		errors          = 0;
		n_push          = 0;
		n_clear         = 0;
		n_ovf_seen      = 0;
		cycles          = 0;
		pred_clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(250);
		test_drain_pause();
		test_no_idle();
		test_random(300);

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d pushes and %0d clears; %0d results carried the overflow flag",
			n_push, n_clear, n_ovf_seen);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
